// ----- rtl/nonorth_delta_coeff_correction_top_assert.svh -----
// Assertion helpers used by the top-level design file.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef NONORTH_DELTA_COEFF_CORRECTION_TOP_ASSERT_SVH
`define NONORTH_DELTA_COEFF_CORRECTION_TOP_ASSERT_SVH

// Same-cycle implication.
`define NDC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ndc assertion failed");

// Next-cycle implication.
`define NDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ndc assertion failed");

`endif

// ----- rtl/ndc_pkg.sv -----
// ----------------------------------------------------------------------------
// ndc_pkg
// Shared types and constants of the delta coefficient / correction pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndc_pkg;

   localparam int unsigned LANES       = 3;
   localparam int unsigned NDIV_STEPS  = 16;  // quotient bits of the unit normal
   localparam int unsigned SQRT_STEPS  = 32;  // root bits of |d|
   localparam int unsigned RECIP_STEPS = 31;  // quotient bits of the coefficient
   localparam int unsigned Q_ONE       = 65536;

   localparam logic [1:0]  KIND_PHYS = 2'd1;
   localparam logic [16:0] UNIT_ONE  = 17'd65536;
   localparam logic [11:0] CLAMP_K   = 12'd3277;  // 0.05 in Q0.16

   typedef logic signed [31:0] q16_type;
   typedef logic signed [17:0] unit_type;
   typedef logic signed [51:0] dot_type;
   typedef logic [51:0]        den_type;
   typedef logic [30:0]        coeff_type;

   typedef struct packed {
      logic [1:0]                kind;
      q16_type  [LANES-1:0]      d;
      unit_type [LANES-1:0]      n;
   } face_type;

   typedef struct packed {
      face_type face;
      dot_type  dot;
   } root_side_type;

endpackage

`default_nettype wire

// ----- rtl/ndc_ndiv.sv -----
// ----------------------------------------------------------------------------
// ndc_ndiv
// Pipelined restoring divider forming the unit normal n = norm / area,
// three lanes, one quotient bit per stage, clamped to +-1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndc_ndiv (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [1:0]                            in_kind,
   input  ndc_pkg::q16_type [ndc_pkg::LANES-1:0] in_d,
   input  ndc_pkg::q16_type [ndc_pkg::LANES-1:0] in_norm,
   input  logic [30:0]                           in_area,
   output logic                                  out_valid,
   output ndc_pkg::face_type                     out_face
);
   import ndc_pkg::*;

   localparam int unsigned N = NDIV_STEPS;

   logic                  valid_ff [0:N];
   logic [1:0]            kind_ff  [0:N];
   q16_type [LANES-1:0]   d_ff     [0:N];
   logic [30:0]           area_ff  [0:N];
   logic [30:0]           rem_ff   [0:N][0:LANES-1];
   logic [N-1:0]          q_ff     [0:N][0:LANES-1];
   logic [LANES-1:0]      over_ff  [0:N];
   logic [LANES-1:0]      neg_ff   [0:N];

   logic [30:0]           area_in;
   logic [31:0]           mag      [0:LANES-1];
   logic [LANES-1:0]      over_in;
   logic [LANES-1:0]      neg_in;

   logic                  out_valid_ff;
   face_type              out_face_ff;
   face_type              face_in;
   logic [16:0]           umag     [0:LANES-1];

   // entry: magnitude, sign and the |norm| >= area clamp test
   always_comb begin
      area_in = (in_area == '0) ? 31'd1 : in_area;
      for (int l = 0; l < LANES; l++) begin
         neg_in[l]  = in_norm[l][31];
         mag[l]     = in_norm[l][31] ? 32'(-in_norm[l]) : 32'(in_norm[l]);
         over_in[l] = mag[l] >= {1'b0, area_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff[0] <= in_kind;
         d_ff[0]    <= in_d;
         area_ff[0] <= area_in;
         over_ff[0] <= over_in;
         neg_ff[0]  <= neg_in;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= over_in[l] ? '0 : mag[l][30:0];
            q_ff[0][l]   <= '0;
         end
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_step
      logic [31:0]      trial [0:LANES-1];
      logic [LANES-1:0] take;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_ff[s][l], 1'b0};
            take[l]  = trial[l] >= {1'b0, area_ff[s]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            kind_ff[s+1] <= kind_ff[s];
            d_ff[s+1]    <= d_ff[s];
            area_ff[s+1] <= area_ff[s];
            over_ff[s+1] <= over_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s+1][l] <= take[l] ? 31'(trial[l] - {1'b0, area_ff[s]})
                                         : trial[l][30:0];
               q_ff[s+1][l]   <= {q_ff[s][l][N-2:0], take[l]};
            end
         end
      end
   end

   // apply clamp and sign
   always_comb begin
      face_in.kind = kind_ff[N];
      face_in.d    = d_ff[N];
      for (int l = 0; l < LANES; l++) begin
         umag[l]      = over_ff[N][l] ? UNIT_ONE : {1'b0, q_ff[N][l]};
         face_in.n[l] = neg_ff[N][l] ? -$signed({1'b0, umag[l]}) : $signed({1'b0, umag[l]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_face_ff <= face_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_face  = out_face_ff;

endmodule

`default_nettype wire

// ----- rtl/ndc_isqrt.sv -----
// ----------------------------------------------------------------------------
// ndc_isqrt
// Pipelined digit-by-digit integer square root of a 64-bit value,
// one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndc_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [63:0]           in_sq,
   input  ndc_pkg::root_side_type in_side,
   output logic                  out_valid,
   output logic [31:0]           out_mag,
   output ndc_pkg::root_side_type out_side
);
   import ndc_pkg::*;

   localparam int unsigned N = SQRT_STEPS;

   logic          valid_ff [0:N];
   logic [63:0]   sq_ff    [0:N];
   logic [33:0]   rem_ff   [0:N];
   logic [31:0]   root_ff  [0:N];
   root_side_type side_ff  [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0]   <= in_sq;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_step
      logic [35:0] rem_t;
      logic [35:0] trial;
      logic        take;

      always_comb begin
         rem_t = {rem_ff[s], sq_ff[s][63:62]};
         trial = {2'b00, root_ff[s], 2'b01};
         take  = rem_t >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[s+1]   <= {sq_ff[s][61:0], 2'b00};
            rem_ff[s+1]  <= take ? 34'(rem_t - trial) : rem_t[33:0];
            root_ff[s+1] <= {root_ff[s][30:0], take};
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_mag   = root_ff[N];
   assign out_side  = side_ff[N];

endmodule

`default_nettype wire

// ----- rtl/ndc_recip.sv -----
// ----------------------------------------------------------------------------
// ndc_recip
// Pipelined restoring divider for 2^48 / den, one quotient bit per stage,
// saturating to the 31-bit maximum when in_sat marks a den of at most 2^17.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndc_recip (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  ndc_pkg::den_type    in_den,
   input  logic                in_sat,
   input  ndc_pkg::face_type   in_face,
   output logic                out_valid,
   output ndc_pkg::coeff_type  out_coeff,
   output ndc_pkg::face_type   out_face
);
   import ndc_pkg::*;

   localparam int unsigned N = RECIP_STEPS;
   // numerator bits above the quotient window: 2^48 >> 31
   localparam den_type REM_INIT = den_type'(2 * Q_ONE);

   logic        valid_ff [0:N];
   den_type     den_ff   [0:N];
   den_type     rem_ff   [0:N];
   logic [N-1:0] q_ff    [0:N];
   logic        sat_ff   [0:N];
   face_type    face_ff  [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= in_den;
         rem_ff[0]  <= REM_INIT;
         q_ff[0]    <= '0;
         sat_ff[0]  <= in_sat;
         face_ff[0] <= in_face;
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_step
      logic [52:0] trial;
      logic        take;

      always_comb begin
         trial = {rem_ff[s], 1'b0};
         take  = trial >= {1'b0, den_ff[s]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s+1]  <= den_ff[s];
            rem_ff[s+1]  <= take ? 52'(trial - {1'b0, den_ff[s]}) : trial[51:0];
            q_ff[s+1]    <= {q_ff[s][N-2:0], take};
            sat_ff[s+1]  <= sat_ff[s];
            face_ff[s+1] <= face_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_coeff = sat_ff[N] ? '1 : q_ff[N];
   assign out_face  = face_ff[N];

endmodule

`default_nettype wire

// ----- rtl/nonorth_delta_coeff_correction_top.sv -----
// ----------------------------------------------------------------------------
// nonorth_delta_coeff_correction_top
// Delta coefficient and non-orthogonal correction vector for one mesh face.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one face per transfer (valid/stall): kind, owner centre,
//   far point, area vector and area, all Q16.16. rsp_* returns one result
//   per face in order: delta_coeff = 1/max(n.d, 0.05|d|, 1 LSB) and the
//   correction n - d*coeff (zero on physical boundary faces).
//   Throughput: one face per clock unless a stall holds the pipeline; a new
//   face may be offered every cycle. Depth is set by the serial units: the
//   unit normal divider (16 stages), the |d| square root (32 stages) and the
//   2^48/den divider (31 stages), plus entry, product, sum, clamp,
//   denominator, multiply, adjust and output registers.
//   Stall: when the output register holds a result and rsp_stall is high,
//   the whole pipeline freezes and req_stall rises; nothing is dropped or
//   repeated. While the output is free or being taken, req_stall stays low.
//   Reset (synchronous, active high) clears every valid bit; payload is not
//   reset. The block holds no state between faces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nonorth_delta_coeff_correction_top (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_own_x,
   input  logic signed [31:0] req_own_y,
   input  logic signed [31:0] req_own_z,
   input  logic signed [31:0] req_far_x,
   input  logic signed [31:0] req_far_y,
   input  logic signed [31:0] req_far_z,
   input  logic signed [31:0] req_norm_x,
   input  logic signed [31:0] req_norm_y,
   input  logic signed [31:0] req_norm_z,
   input  logic [30:0]        req_area,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_delta_coeff,
   output logic signed [31:0] rsp_corr_x,
   output logic signed [31:0] rsp_corr_y,
   output logic signed [31:0] rsp_corr_z
);
   import ndc_pkg::*;

`include "nonorth_delta_coeff_correction_top_assert.svh"

   // global advance: everything moves unless a finished result is held
   logic en;

   q16_type [LANES-1:0] own;
   q16_type [LANES-1:0] far_pt;
   q16_type [LANES-1:0] norm;
   q16_type [LANES-1:0] d_in;
   logic signed [32:0]  diff [0:LANES-1];

   logic          nd_valid;
   face_type      nd_face;

   // products
   logic          p_valid_ff;
   face_type      p_face_ff;
   logic [63:0]   p_sq_ff  [0:LANES-1];
   logic [63:0]   p_sq_in  [0:LANES-1];
   logic signed [49:0] p_nd_ff [0:LANES-1];
   logic signed [49:0] p_nd_in [0:LANES-1];

   // sums
   logic          s_valid_ff;
   logic [63:0]   s_sq_ff;
   logic [63:0]   s_sq_in;
   root_side_type s_side_ff;
   root_side_type s_side_in;

   logic          i_valid;
   logic [31:0]   i_mag;
   root_side_type i_side;

   // clamp term
   logic          c_valid_ff;
   logic [43:0]   c_clamp_ff;
   dot_type       c_dot_ff;
   face_type      c_face_ff;

   // denominator
   logic          d_valid_ff;
   den_type       d_den_ff;
   den_type       d_den_in;
   logic          d_sat_ff;
   face_type      d_face_ff;

   logic          r_valid;
   coeff_type     r_coeff;
   face_type      r_face;

   // d * coeff
   logic          m_valid_ff;
   logic [1:0]    m_kind_ff;
   coeff_type     m_coeff_ff;
   unit_type [LANES-1:0] m_n_ff;
   logic signed [63:0] m_prod_ff [0:LANES-1];
   logic signed [63:0] m_prod_in [0:LANES-1];

   // n*2^16 - prod, truncated toward zero
   logic          a_valid_ff;
   logic [1:0]    a_kind_ff;
   coeff_type     a_coeff_ff;
   logic signed [47:0] a_q_ff [0:LANES-1];
   logic signed [47:0] a_q_in [0:LANES-1];
   logic signed [63:0] wide   [0:LANES-1];
   logic signed [63:0] adj    [0:LANES-1];

   // output register
   logic          rsp_valid_ff;
   coeff_type     rsp_coeff_ff;
   q16_type       rsp_corr_ff [0:LANES-1];
   q16_type       rsp_corr_in [0:LANES-1];

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---- entry: d = far - own, saturated --------------------------------
   assign own[0]    = req_own_x;
   assign own[1]    = req_own_y;
   assign own[2]    = req_own_z;
   assign far_pt[0] = req_far_x;
   assign far_pt[1] = req_far_y;
   assign far_pt[2] = req_far_z;
   assign norm[0]   = req_norm_x;
   assign norm[1]   = req_norm_y;
   assign norm[2]   = req_norm_z;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         diff[l] = {far_pt[l][31], far_pt[l]} - {own[l][31], own[l]};
         if (diff[l][32] != diff[l][31]) begin
            d_in[l] = diff[l][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            d_in[l] = diff[l][31:0];
         end
      end
   end

   ndc_ndiv u_ndiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_kind   (req_kind),
      .in_d      (d_in),
      .in_norm   (norm),
      .in_area   (req_area),
      .out_valid (nd_valid),
      .out_face  (nd_face)
   );

   // ---- squares and n.d products ---------------------------------------
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         p_sq_in[l] = 64'(64'($signed(nd_face.d[l])) * 64'($signed(nd_face.d[l])));
         p_nd_in[l] = 50'($signed(nd_face.n[l])) * 50'($signed(nd_face.d[l]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= nd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_face_ff <= nd_face;
         for (int l = 0; l < LANES; l++) begin
            p_sq_ff[l] <= p_sq_in[l];
            p_nd_ff[l] <= p_nd_in[l];
         end
      end
   end

   // ---- |d|^2 and n.d ---------------------------------------------------
   always_comb begin
      s_sq_in        = p_sq_ff[0] + p_sq_ff[1] + p_sq_ff[2];
      s_side_in.face = p_face_ff;
      s_side_in.dot  = 52'(p_nd_ff[0]) + 52'(p_nd_ff[1]) + 52'(p_nd_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_sq_ff   <= s_sq_in;
         s_side_ff <= s_side_in;
      end
   end

   ndc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid_ff),
      .in_sq     (s_sq_ff),
      .in_side   (s_side_ff),
      .out_valid (i_valid),
      .out_mag   (i_mag),
      .out_side  (i_side)
   );

   // ---- 0.05 |d| ---------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= i_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_clamp_ff <= 44'(i_mag) * 44'(CLAMP_K);
         c_dot_ff   <= i_side.dot;
         c_face_ff  <= i_side.face;
      end
   end

   // ---- den = max(n.d, 0.05|d|, one LSB) --------------------------------
   always_comb begin
      d_den_in = den_type'(Q_ONE);
      if (den_type'(c_clamp_ff) > d_den_in) begin
         d_den_in = den_type'(c_clamp_ff);
      end
      if (!c_dot_ff[51] && den_type'(c_dot_ff) > d_den_in) begin
         d_den_in = den_type'(c_dot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_den_ff  <= d_den_in;
         d_sat_ff  <= d_den_in <= den_type'(2 * Q_ONE);
         d_face_ff <= c_face_ff;
      end
   end

   ndc_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .in_den    (d_den_ff),
      .in_sat    (d_sat_ff),
      .in_face   (d_face_ff),
      .out_valid (r_valid),
      .out_coeff (r_coeff),
      .out_face  (r_face)
   );

   // ---- d * coeff -------------------------------------------------------
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         m_prod_in[l] = 64'($signed(r_face.d[l])) * 64'($signed({1'b0, r_coeff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_kind_ff  <= r_face.kind;
         m_coeff_ff <= r_coeff;
         m_n_ff     <= r_face.n;
         for (int l = 0; l < LANES; l++) begin
            m_prod_ff[l] <= m_prod_in[l];
         end
      end
   end

   // ---- n - d*coeff in Q32.32, back to Q16.16 toward zero ---------------
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         wide[l]   = (64'($signed(m_n_ff[l])) <<< 16) - m_prod_ff[l];
         adj[l]    = wide[l][63] ? wide[l] + 64'sd65535 : wide[l];
         a_q_in[l] = adj[l][63:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_kind_ff  <= m_kind_ff;
         a_coeff_ff <= m_coeff_ff;
         for (int l = 0; l < LANES; l++) begin
            a_q_ff[l] <= a_q_in[l];
         end
      end
   end

   // ---- saturate, zero on physical boundary, output register ------------
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (a_kind_ff == KIND_PHYS) begin
            rsp_corr_in[l] = '0;
         end else if (a_q_ff[l][47:31] != {17{a_q_ff[l][47]}}) begin
            rsp_corr_in[l] = a_q_ff[l][47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            rsp_corr_in[l] = a_q_ff[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_coeff_ff <= a_coeff_ff;
         for (int l = 0; l < LANES; l++) begin
            rsp_corr_ff[l] <= rsp_corr_in[l];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_delta_coeff = rsp_coeff_ff;
   assign rsp_corr_x      = rsp_corr_ff[0];
   assign rsp_corr_y      = rsp_corr_ff[1];
   assign rsp_corr_z      = rsp_corr_ff[2];

   // ---- checks ----------------------------------------------------------
   `NDC_ASSERT_NEXT(a_phys_zero, en && a_valid_ff && a_kind_ff == KIND_PHYS, rsp_corr_x == '0 && rsp_corr_y == '0 && rsp_corr_z == '0)
   `NDC_ASSERT_IMPL(a_den_floor, d_valid_ff, d_den_ff >= den_type'(Q_ONE))
   `NDC_ASSERT_NEXT(a_freeze, rsp_valid_ff && rsp_stall, $stable(a_valid_ff) && $stable(a_coeff_ff))

endmodule

`default_nettype wire
